// ----- rtl/dcpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpc_pkg
// Shared types and constants for the detent-count position controller.
// ----------------------------------------------------------------------------
package dcpc_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0]  BRAKE_DRIVE    = 8'd250;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd200;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_SPEED_DOWN  = 2'd0;
    localparam logic [1:0] REG_SPEED_UP    = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE_MS = 2'd2;

    typedef struct packed {
        logic [1:0]  target_position;
        logic        switch_level;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0] drive_down;
        logic [7:0] drive_up;
        logic       in_position;
        logic [1:0] position_now;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  speed_down;
        logic [7:0]  speed_up;
        logic [15:0] debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  stop_index;
        logic        prior_switch;
        logic [31:0] event_time;
        logic        moving_up;
        logic [7:0]  held_down_drive;
        logic [7:0]  held_up_drive;
    } ctrl_state_t;

endpackage

// ----- rtl/dcpc_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpc_step
// Next-state and result logic for one switch sample.
// ----------------------------------------------------------------------------
module dcpc_step
(
    input  dcpc_pkg::in_item_t    item,
    input  dcpc_pkg::cfg_t        cfg,
    input  dcpc_pkg::ctrl_state_t state,
    output dcpc_pkg::ctrl_state_t state_next,
    output dcpc_pkg::out_item_t   result
);

    logic [31:0] since_event;
    logic        elapsed;
    logic        rising;
    logic        settled;

    assign since_event = item.now_ms - state.event_time;
    assign elapsed     = since_event > {16'd0, cfg.debounce_ms};
    assign rising      = item.switch_level & ~state.prior_switch;

    always_comb
    begin
        state_next = state;
        settled    = 1'b0;
        if (item.target_position > state.stop_index)
        begin
            state_next.moving_up = 1'b1;
            if (rising && elapsed)
            begin
                state_next.stop_index = state.stop_index + 2'd1;
                state_next.event_time = item.now_ms;
            end
            state_next.held_down_drive = 8'd0;
            state_next.held_up_drive   = cfg.speed_up;
        end
        else if (item.target_position < state.stop_index)
        begin
            state_next.moving_up = 1'b0;
            if (rising && elapsed)
            begin
                state_next.stop_index = state.stop_index - 2'd1;
                state_next.event_time = item.now_ms;
            end
            state_next.held_down_drive = cfg.speed_down;
            state_next.held_up_drive   = 8'd0;
        end
        else if (!item.switch_level)
        begin
            // overshot the stop: back off against the last direction
            if (state.moving_up)
            begin
                state_next.held_down_drive = cfg.speed_down;
                state_next.held_up_drive   = 8'd0;
            end
            else
            begin
                state_next.held_down_drive = 8'd0;
                state_next.held_up_drive   = cfg.speed_up;
            end
            if (state.prior_switch && elapsed)
            begin
                state_next.moving_up = ~state.moving_up;
            end
            state_next.event_time = item.now_ms;
        end
        else if (elapsed)
        begin
            state_next.held_down_drive = dcpc_pkg::BRAKE_DRIVE;
            state_next.held_up_drive   = dcpc_pkg::BRAKE_DRIVE;
            state_next.event_time      = item.now_ms;
            settled                    = 1'b1;
        end
        state_next.prior_switch = item.switch_level;
    end

    assign result.drive_down   = state_next.held_down_drive;
    assign result.drive_up     = state_next.held_up_drive;
    assign result.in_position  = settled;
    assign result.position_now = state_next.stop_index;

endmodule

// ----- rtl/detent_count_position_controller_core.sv -----
`timescale 1ns / 1ps
// Each result is registered into the main output entry, or into the skid entry while the main entry waits.
// Throughput: one sample per cycle while in_stall is low; the update is one pass of compare/subtract logic.
// A two-entry output buffer keeps input flowing while a result waits; in_stall
// rises only when both entries are full.
// Reset: stop 0, switch seen pressed, event time 0, drives 0, debounce 200, speeds 0.
// ----------------------------------------------------------------------------
// detent_count_position_controller_core
// Counts debounced switch edges to track the carriage stop and drives the motor.
// ----------------------------------------------------------------------------
module detent_count_position_controller_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [dcpc_pkg::DATA_W-1:0]   pwdata,
    output logic [dcpc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  dcpc_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output dcpc_pkg::out_item_t           out_data
);

    dcpc_pkg::cfg_t        cfg_reg;
    dcpc_pkg::ctrl_state_t state_reg;
    dcpc_pkg::ctrl_state_t state_next;
    dcpc_pkg::out_item_t   result;

    dcpc_pkg::out_item_t   main_reg, main_next;
    dcpc_pkg::out_item_t   skid_reg, skid_next;
    logic                  main_valid_reg, main_valid_next;
    logic                  skid_valid_reg, skid_valid_next;

    logic in_xfer;
    logic out_xfer;
    logic cfg_write;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_down  <= 8'd0;
            cfg_reg.speed_up    <= 8'd0;
            cfg_reg.debounce_ms <= dcpc_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                dcpc_pkg::REG_SPEED_DOWN:  cfg_reg.speed_down  <= pwdata[7:0];
                dcpc_pkg::REG_SPEED_UP:    cfg_reg.speed_up    <= pwdata[7:0];
                dcpc_pkg::REG_DEBOUNCE_MS: cfg_reg.debounce_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dcpc_pkg::REG_SPEED_DOWN:  prdata = {24'd0, cfg_reg.speed_down};
            dcpc_pkg::REG_SPEED_UP:    prdata = {24'd0, cfg_reg.speed_up};
            dcpc_pkg::REG_DEBOUNCE_MS: prdata = {16'd0, cfg_reg.debounce_ms};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- control update ----------------
    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid & ~skid_valid_reg;
    assign out_xfer = main_valid_reg & ~out_stall;

    dcpc_step u_step
    (
        .item       (in_data),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.stop_index      <= 2'd0;
            state_reg.prior_switch    <= 1'b1;
            state_reg.event_time      <= 32'd0;
            state_reg.moving_up       <= 1'b0;
            state_reg.held_down_drive <= 8'd0;
            state_reg.held_up_drive   <= 8'd0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- output buffer ----------------
    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_xfer)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_next       = result;
                skid_valid_next = in_xfer;
            end
            else
            begin
                main_next       = result;
                main_valid_next = in_xfer;
            end
        end
        else if (main_valid_reg)
        begin
            if (in_xfer)
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            main_next       = result;
            main_valid_next = in_xfer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

`ifndef SYNTH
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid)
        else $error("no result after sample transfer");

    a_brake_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.in_position) |->
        (out_data.drive_down == dcpc_pkg::BRAKE_DRIVE &&
         out_data.drive_up == dcpc_pkg::BRAKE_DRIVE))
        else $error("in-position without brake drive");

    a_stop_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.stop_index != $past(state_reg.stop_index)) |->
        (state_reg.stop_index == 2'($past(state_reg.stop_index) + 2'd1) ||
         state_reg.stop_index == 2'($past(state_reg.stop_index) - 2'd1)))
        else $error("stop index moved by more than one");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_xfer) |-> $stable(state_reg))
        else $error("state changed without a sample transfer");
`endif

endmodule
